FILE: sv/wdmb_pkg.sv
// Shared types, constants, register codes and sine table for the DFT beamformer.
package wdmb_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 48;
   localparam int CSR_WIDTH    = 32;
   localparam int COUNT_WIDTH  = 13;
   localparam int POS_WIDTH    = 32;
   localparam int TABLE_DEPTH  = 1024;
   localparam int TAB_AW       = $clog2(TABLE_DEPTH + 1);
   localparam int OFS_W        = $clog2(TABLE_DEPTH);
   localparam int IDX_W        = $clog2(4 * TABLE_DEPTH);
   localparam int TAB_W        = 15;
   localparam int NUM_LANES    = 4;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TABLE_MAX   = 64'd32767;

   localparam logic [1:0] CSR_WAVENUMBER  = 2'd0;
   localparam logic [1:0] CSR_OUT_X       = 2'd1;
   localparam logic [1:0] CSR_OUT_Y       = 2'd2;
   localparam logic [1:0] CSR_INPUT_COUNT = 2'd3;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic signed [POS_WIDTH-1:0]    pos_type;
   typedef logic [TAB_W-1:0]               tab_entry_type;
   typedef tab_entry_type                  sine_tab_type [TABLE_DEPTH+1];

   typedef struct packed {
      logic k_en;
      logic p_en;
      logic f_en;
   } phase_ctl_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clear;
   } lane_ctl_type;

   function automatic acc_type sat_acc(logic signed [ACC_WIDTH:0] v);
      if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
         return v[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      return v[ACC_WIDTH-1:0];
   endfunction

   // Q30 Taylor series of sin over the first quadrant, scaled to 15 bits
   function automatic tab_entry_type sine_entry(int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] r;
      longint      s;
      x  = (HALF_PI_Q30 * 64'(k) + 64'(TABLE_DEPTH / 2)) / TABLE_DEPTH;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      t = ((t * x2) >> 30) / 6;   s = s - longint'(t);
      t = ((t * x2) >> 30) / 20;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 42;  s = s - longint'(t);
      t = ((t * x2) >> 30) / 72;  s = s + longint'(t);
      t = ((t * x2) >> 30) / 110; s = s - longint'(t);
      t = ((t * x2) >> 30) / 156; s = s + longint'(t);
      t = ((t * x2) >> 30) / 210; s = s - longint'(t);
      t = ((t * x2) >> 30) / 272; s = s + longint'(t);
      t = ((t * x2) >> 30) / 342; s = s - longint'(t);
      t = ((t * x2) >> 30) / 420; s = s + longint'(t);
      if (s < 0) s = 0;
      r = (64'(s) * TABLE_MAX + (64'd1 << 29)) >> 30;
      if (r > TABLE_MAX) r = TABLE_MAX;
      return TAB_W'(r);
   endfunction

   function automatic sine_tab_type build_sine_table();
      sine_tab_type tab;
      for (int k = 0; k <= TABLE_DEPTH; k++) tab[k] = sine_entry(k);
      return tab;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_sine_table();

endpackage

FILE: sv/wdmb_req_if.sv
// Input channel: positions, weight and four complex data elements.
interface wdmb_req_if;
   import wdmb_pkg::*;
   logic       valid;
   logic       ready;
   pos_type    in_x;
   pos_type    in_y;
   sample_type weight_re;
   sample_type weight_im;
   sample_type a_re;
   sample_type a_im;
   sample_type b_re;
   sample_type b_im;
   sample_type c_re;
   sample_type c_im;
   sample_type d_re;
   sample_type d_im;
   modport source(output valid, in_x, in_y, weight_re, weight_im, a_re, a_im, b_re, b_im,
                  c_re, c_im, d_re, d_im, input ready);
   modport sink(input valid, in_x, in_y, weight_re, weight_im, a_re, a_im, b_re, b_im,
                c_re, c_im, d_re, d_im, output ready);
endinterface

FILE: sv/wdmb_rsp_if.sv
// Result channel: eight accumulated sums.
interface wdmb_rsp_if;
   import wdmb_pkg::*;
   logic    valid;
   logic    ready;
   acc_type sum_a_re;
   acc_type sum_a_im;
   acc_type sum_b_re;
   acc_type sum_b_im;
   acc_type sum_c_re;
   acc_type sum_c_im;
   acc_type sum_d_re;
   acc_type sum_d_im;
   modport source(output valid, sum_a_re, sum_a_im, sum_b_re, sum_b_im, sum_c_re, sum_c_im,
                  sum_d_re, sum_d_im, input ready);
   modport sink(input valid, sum_a_re, sum_a_im, sum_b_re, sum_b_im, sum_c_re, sum_c_im,
                sum_d_re, sum_d_im, output ready);
endinterface

FILE: sv/wdmb_ram.sv
// Generic RAM: one write port, two registered read ports.
module wdmb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule

FILE: sv/wdmb_phase.sv
// Phase front: triple product modulo 2^48 in 24-bit partial products, then table index.
module wdmb_phase (
   input  logic                        clock,
   input  wdmb_pkg::phase_ctl_type     ctl,
   input  logic [31:0]                 wavenumber,
   input  wdmb_pkg::pos_type           out_x,
   input  wdmb_pkg::pos_type           out_y,
   input  wdmb_pkg::pos_type           in_x,
   input  wdmb_pkg::pos_type           in_y,
   output logic [wdmb_pkg::IDX_W-1:0]  index
);
   import wdmb_pkg::*;

   logic signed [64:0] kxp;
   logic signed [64:0] kyp;
   logic [47:0] kx_ff, ky_ff;
   logic [47:0] ix, iy;
   logic [47:0] llx_in, c1x, c2x, lly_in, c1y, c2y;
   logic [23:0] cx_in, cy_in;
   logic [47:0] llx_ff, lly_ff;
   logic [23:0] cx_ff, cy_ff;
   logic [47:0] frac;
   logic [47:0] frac_rnd;
   logic [IDX_W-1:0] index_ff;

   assign kxp = $signed({1'b0, wavenumber}) * out_x;
   assign kyp = $signed({1'b0, wavenumber}) * out_y;
   assign ix  = {{16{in_x[31]}}, in_x};
   assign iy  = {{16{in_y[31]}}, in_y};

   // only the low 24 bits of each cross product reach the 48-bit fraction
   assign llx_in = kx_ff[23:0] * ix[23:0];
   assign c1x    = kx_ff[23:0] * ix[47:24];
   assign c2x    = kx_ff[47:24] * ix[23:0];
   assign cx_in  = c1x[23:0] + c2x[23:0];
   assign lly_in = ky_ff[23:0] * iy[23:0];
   assign c1y    = ky_ff[23:0] * iy[47:24];
   assign c2y    = ky_ff[47:24] * iy[23:0];
   assign cy_in  = c1y[23:0] + c2y[23:0];

   assign frac     = llx_ff + lly_ff + {cx_ff, 24'd0} + {cy_ff, 24'd0};
   assign frac_rnd = frac + (48'd1 << (47 - IDX_W));

   always_ff @(posedge clock) begin
      if (ctl.k_en) begin
         kx_ff <= kxp[47:0];
         ky_ff <= kyp[47:0];
      end
      if (ctl.p_en) begin
         llx_ff <= llx_in;
         lly_ff <= lly_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
      if (ctl.f_en) index_ff <= frac_rnd[47 -: IDX_W];
   end

   assign index = index_ff;
endmodule

FILE: sv/wdmb_lane.sv
// One element lane: complex multiply by the rotated weight, saturating accumulate.
module wdmb_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  wdmb_pkg::lane_ctl_type ctl,
   input  wdmb_pkg::sample_type   d_re,
   input  wdmb_pkg::sample_type   d_im,
   input  wdmb_pkg::sample_type   w_re,
   input  wdmb_pkg::sample_type   w_im,
   output wdmb_pkg::acc_type      sum_re,
   output wdmb_pkg::acc_type      sum_im
);
   import wdmb_pkg::*;

   logic signed [2*SAMPLE_WIDTH-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [2*SAMPLE_WIDTH:0]   delta_re, delta_im;
   logic signed [ACC_WIDTH:0]        raw_re, raw_im;
   acc_type acc_re_ff, acc_im_ff;

   assign delta_re = p_rr_ff - p_ii_ff;
   assign delta_im = p_ir_ff + p_ri_ff;
   assign raw_re   = acc_re_ff + delta_re;
   assign raw_im   = acc_im_ff + delta_im;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         p_rr_ff <= d_re * w_re;
         p_ii_ff <= d_im * w_im;
         p_ir_ff <= d_im * w_re;
         p_ri_ff <= d_re * w_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (ctl.acc_en) begin
         acc_re_ff <= sat_acc(raw_re);
         acc_im_ff <= sat_acc(raw_im);
      end
   end

   assign sum_re = acc_re_ff;
   assign sum_im = acc_im_ff;
endmodule

FILE: sv/weighted_dft_matrix_beamformer.sv
// Weighted 2-D DFT beamformer top level: sequencer, weight rotation, lanes and result merge.
// Items are taken one at a time: req_bus.ready is high only in IDLE, and each item walks
//   the shared phase, table and rotation steps in order before the four lanes accumulate it.
//   A completed point's result is registered onto rsp_bus from E, once any earlier one is taken.
// Reset: synchronous, active high; sets the configuration defaults, clears sums and counts, then
//   a fill pass loads all 1025 sine table RAM entries while req_bus.ready stays low.
module weighted_dft_matrix_beamformer #(
   parameter int MAX_INPUTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [1:0]                      csr_index,
   input  logic [wdmb_pkg::CSR_WIDTH-1:0]  csr_wdata,
   wdmb_req_if.sink                        req_bus,
   wdmb_rsp_if.source                      rsp_bus
);
   import wdmb_pkg::*;

   localparam int CW = $clog2(MAX_INPUTS + 1);

   localparam logic [3:0] ST_FILL = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_K    = 4'd2;
   localparam logic [3:0] ST_P    = 4'd3;
   localparam logic [3:0] ST_F    = 4'd4;
   localparam logic [3:0] ST_T    = 4'd5;
   localparam logic [3:0] ST_W    = 4'd6;
   localparam logic [3:0] ST_R    = 4'd7;
   localparam logic [3:0] ST_L    = 4'd8;
   localparam logic [3:0] ST_A    = 4'd9;
   localparam logic [3:0] ST_E    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [TAB_AW-1:0] fill_ff;
   logic [31:0] wn_ff;
   pos_type ox_ff, oy_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [CW-1:0] items_ff;
   logic [CW-1:0] limit;
   logic [CW:0] seen_next;
   logic done, emit, accept;

   pos_type ix_ff, iy_ff;
   sample_type wr_ff, wi_ff;
   sample_type d_ff [2*NUM_LANES];

   phase_ctl_type phase_ctl;
   lane_ctl_type lane_ctl;
   logic [IDX_W-1:0] index;
   logic [1:0] quad;
   logic [TAB_AW-1:0] addr_k, addr_dk;
   logic [TAB_W-1:0] s_k, s_dk;
   sample_type sn, cs;
   logic signed [2*SAMPLE_WIDTH-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [2*SAMPLE_WIDTH:0] v_re, v_im;
   sample_type rr_ff, ri_ff;
   acc_type lane_sum [2*NUM_LANES];
   acc_type sum_ff [2*NUM_LANES];
   logic rsp_valid_ff;

   function automatic sample_type round15(logic signed [2*SAMPLE_WIDTH:0] v);
      logic signed [2*SAMPLE_WIDTH+1:0] u;
      logic signed [2*SAMPLE_WIDTH+1:0] q;
      u = v + 16384;
      q = u >>> 15;
      if (q > 32767) return 16'sh7fff;
      if (q < -32768) return 16'sh8000;
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         wn_ff  <= 32'd65536;
         ox_ff  <= '0;
         oy_ff  <= '0;
         cnt_ff <= COUNT_WIDTH'(1);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_WAVENUMBER:  wn_ff  <= csr_wdata;
            CSR_OUT_X:       ox_ff  <= csr_wdata;
            CSR_OUT_Y:       oy_ff  <= csr_wdata;
            CSR_INPUT_COUNT: cnt_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cnt_ff == '0) limit = CW'(1);
      else if (32'(cnt_ff) > 32'(MAX_INPUTS)) limit = CW'(MAX_INPUTS);
      else limit = CW'(cnt_ff);
   end
   assign seen_next = {1'b0, items_ff} + 1'b1;
   assign done      = seen_next >= {1'b0, limit};
   assign emit      = (state_ff == ST_E) && done && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: if (fill_ff == TAB_AW'(TABLE_DEPTH)) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = ST_K;
         ST_K:    state_in = ST_P;
         ST_P:    state_in = ST_F;
         ST_F:    state_in = ST_T;
         ST_T:    state_in = ST_W;
         ST_W:    state_in = ST_R;
         ST_R:    state_in = ST_L;
         ST_L:    state_in = ST_A;
         ST_A:    state_in = ST_E;
         ST_E:    if (!done || emit) state_in = ST_IDLE;
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff  <= '0;
         items_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FILL) fill_ff <= fill_ff + 1'b1;
         if (state_ff == ST_E) begin
            if (!done) items_ff <= seen_next[CW-1:0];
            else if (emit) items_ff <= '0;
         end
      end
   end

   // hold the item for the whole walk
   always_ff @(posedge clock) begin
      if (accept) begin
         ix_ff   <= req_bus.in_x;
         iy_ff   <= req_bus.in_y;
         wr_ff   <= req_bus.weight_re;
         wi_ff   <= req_bus.weight_im;
         d_ff[0] <= req_bus.a_re;
         d_ff[1] <= req_bus.a_im;
         d_ff[2] <= req_bus.b_re;
         d_ff[3] <= req_bus.b_im;
         d_ff[4] <= req_bus.c_re;
         d_ff[5] <= req_bus.c_im;
         d_ff[6] <= req_bus.d_re;
         d_ff[7] <= req_bus.d_im;
      end
   end

   assign phase_ctl.k_en = (state_ff == ST_K);
   assign phase_ctl.p_en = (state_ff == ST_P);
   assign phase_ctl.f_en = (state_ff == ST_F);

   wdmb_phase u_phase (
      .clock      (clock),
      .ctl        (phase_ctl),
      .wavenumber (wn_ff),
      .out_x      (ox_ff),
      .out_y      (oy_ff),
      .in_x       (ix_ff),
      .in_y       (iy_ff),
      .index      (index)
   );

   assign quad    = index[IDX_W-1 -: 2];
   assign addr_k  = {1'b0, index[OFS_W-1:0]};
   assign addr_dk = TAB_AW'(TABLE_DEPTH) - addr_k;

   wdmb_ram #(
      .WIDTH (TAB_W),
      .DEPTH (TABLE_DEPTH + 1)
   ) u_sine_ram (
      .clock   (clock),
      .we      (state_ff == ST_FILL),
      .waddr   (fill_ff),
      .wdata   (SINE_TABLE[fill_ff]),
      .raddr_a (addr_k),
      .raddr_b (addr_dk),
      .rdata_a (s_k),
      .rdata_b (s_dk)
   );

   always_comb begin
      case (quad)
         2'd0: begin
            sn = $signed({1'b0, s_k});
            cs = $signed({1'b0, s_dk});
         end
         2'd1: begin
            sn = $signed({1'b0, s_dk});
            cs = -$signed({1'b0, s_k});
         end
         2'd2: begin
            sn = -$signed({1'b0, s_k});
            cs = -$signed({1'b0, s_dk});
         end
         default: begin
            sn = -$signed({1'b0, s_dk});
            cs = $signed({1'b0, s_k});
         end
      endcase
   end

   assign v_re = pa_ff - pb_ff;
   assign v_im = pc_ff + pd_ff;

   // rotate the weight, then round to Q1.15
   always_ff @(posedge clock) begin
      if (state_ff == ST_W) begin
         pa_ff <= wr_ff * cs;
         pb_ff <= wi_ff * sn;
         pc_ff <= wr_ff * sn;
         pd_ff <= wi_ff * cs;
      end
      if (state_ff == ST_R) begin
         rr_ff <= round15(v_re);
         ri_ff <= round15(v_im);
      end
   end

   assign lane_ctl.mul_en = (state_ff == ST_L);
   assign lane_ctl.acc_en = (state_ff == ST_A);
   assign lane_ctl.clear  = emit;

   for (genvar e = 0; e < NUM_LANES; e++) begin : g_lane
      wdmb_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl),
         .d_re   (d_ff[2*e]),
         .d_im   (d_ff[2*e+1]),
         .w_re   (rr_ff),
         .w_im   (ri_ff),
         .sum_re (lane_sum[2*e]),
         .sum_im (lane_sum[2*e+1])
      );
   end

   // merge the lane sums into the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         for (int i = 0; i < 2*NUM_LANES; i++) sum_ff[i] <= lane_sum[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (emit) rsp_valid_ff <= 1'b1;
      else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.sum_a_re = sum_ff[0];
   assign rsp_bus.sum_a_im = sum_ff[1];
   assign rsp_bus.sum_b_re = sum_ff[2];
   assign rsp_bus.sum_b_im = sum_ff[3];
   assign rsp_bus.sum_c_re = sum_ff[4];
   assign rsp_bus.sum_c_im = sum_ff[5];
   assign rsp_bus.sum_d_re = sum_ff[6];
   assign rsp_bus.sum_d_im = sum_ff[7];

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_K)
      else $error("transfer did not start the phase step");

   a_fill_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> !req_bus.ready)
      else $error("input taken during table fill");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> items_ff < CW'(MAX_INPUTS))
      else $error("item count reached the largest count without a result");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && items_ff == '0)
      else $error("result not presented after emit");
endmodule

FILE: test/wdmb_sums_board.sv
`timescale 1ns / 1ps
// Beamformer sum predictor and result scoreboard.
import wdmb_pkg::*;

class wdmb_sums_board;

   typedef struct {
      acc_type sums [8];
   } point_sums_type;

   logic [31:0] wavenumber;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [12:0] input_count;
   acc_type     acc [8];
   int          items_seen;
   int          mismatches;
   point_sums_type pending_points [$];
   int          sine_q [TABLE_DEPTH+1];

   function new();
      int k;
      int n;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] r;
      longint      s;
      for (k = 0; k <= TABLE_DEPTH; k++) begin
         x  = (64'd1686629713 * 64'(k) + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
         x2 = (x * x) >> 30;
         t  = x;
         s  = longint'(x);
         for (n = 1; n <= 10; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) s = s - longint'(t);
            else s = s + longint'(t);
         end
         if (s < 0) s = 0;
         r = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (r > 64'd32767) r = 64'd32767;
         sine_q[k] = int'(r);
      end
      mismatches = 0;
      clear_state();
   endfunction

   function void clear_state();
      wavenumber  = 32'd65536;
      out_x       = '0;
      out_y       = '0;
      input_count = 13'd1;
      foreach (acc[e]) acc[e] = '0;
      items_seen = 0;
   endfunction

   function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
         CSR_WAVENUMBER:  wavenumber  = data;
         CSR_OUT_X:       out_x       = data;
         CSR_OUT_Y:       out_y       = data;
         CSR_INPUT_COUNT: input_count = data[12:0];
         default: ;
      endcase
   endfunction

   function longint round_q15(longint v);
      longint u;
      longint q;
      u = v + 16384;
      q = u >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function acc_type add_sat(acc_type a, longint d);
      logic signed [63:0] s;
      s = 64'(a) + d;
      if (s > 64'sh7FFF_FFFF_FFFF) return {1'b0, {47{1'b1}}};
      if (s < -64'sh8000_0000_0000) return {1'b1, {47{1'b0}}};
      return s[47:0];
   endfunction

   // Accumulate one transfer; queue the sums when the point completes.
   function void note_item(pos_type in_x, pos_type in_y, sample_type wre, sample_type wim,
                           sample_type data [8]);
      logic [63:0] px;
      logic [63:0] py;
      logic [63:0] f;
      logic [63:0] m;
      int q;
      int k;
      int limit;
      longint sn;
      longint cs;
      longint rr;
      longint ri;
      longint dr;
      longint di;
      point_sums_type p;
      px = 64'(wavenumber) * 64'(longint'($signed(out_x)));
      px = px * 64'(longint'(in_x));
      py = 64'(wavenumber) * 64'(longint'($signed(out_y)));
      py = py * 64'(longint'(in_y));
      f = (px + py) & ((64'd1 << 48) - 1);
      m = ((f * 64'(4 * TABLE_DEPTH)) + (64'd1 << 47)) >> 48;
      m = m % 64'(4 * TABLE_DEPTH);
      q = int'(m) / TABLE_DEPTH;
      k = int'(m) % TABLE_DEPTH;
      case (q)
         0: begin sn = sine_q[k]; cs = sine_q[TABLE_DEPTH - k]; end
         1: begin sn = sine_q[TABLE_DEPTH - k]; cs = -sine_q[k]; end
         2: begin sn = -sine_q[k]; cs = -sine_q[TABLE_DEPTH - k]; end
         default: begin sn = -sine_q[TABLE_DEPTH - k]; cs = sine_q[k]; end
      endcase
      rr = round_q15(longint'(wre) * cs - longint'(wim) * sn);
      ri = round_q15(longint'(wre) * sn + longint'(wim) * cs);
      for (int e = 0; e < 4; e++) begin
         dr = data[2 * e];
         di = data[2 * e + 1];
         acc[2 * e]     = add_sat(acc[2 * e], dr * rr - di * ri);
         acc[2 * e + 1] = add_sat(acc[2 * e + 1], di * rr + dr * ri);
      end
      limit = input_count;
      if (limit == 0) limit = 1;
      if (limit > 4096) limit = 4096;
      items_seen++;
      if (items_seen < limit) return;
      foreach (acc[e]) begin
         p.sums[e] = acc[e];
         acc[e] = '0;
      end
      pending_points.push_back(p);
      items_seen = 0;
   endfunction

   function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endfunction

   function void check_sums(acc_type got [8]);
      point_sums_type p;
      if (pending_points.size() == 0) begin
         report("result with no sums pending");
         return;
      end
      p = pending_points.pop_front();
      foreach (got[e])
         if (got[e] !== p.sums[e])
            report($sformatf("sum %0d got %h want %h", e, got[e], p.sums[e]));
   endfunction
endclass

FILE: test/weighted_dft_matrix_beamformer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the weighted 2-D DFT beamformer.
module weighted_dft_matrix_beamformer_test;
   import wdmb_pkg::*;

   logic clock;
   logic reset;
   logic csr_wen;
   logic [1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;
   logic hold_off;
   bit   rsp_done;

   wdmb_req_if req_bus();
   wdmb_rsp_if rsp_bus();
   wdmb_sums_board board;

   weighted_dft_matrix_beamformer dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("FAILURE");
      $finish;
   end

   task automatic write_csr(logic [1:0] index, logic [31:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      board.write_reg(index, data);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Wait for every pending point, then let the pipeline drain.
   task automatic settle();
      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_item(pos_type in_x, pos_type in_y, sample_type wre, sample_type wim,
                            sample_type data [8], bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.in_x      <= in_x;
      req_bus.in_y      <= in_y;
      req_bus.weight_re <= wre;
      req_bus.weight_im <= wim;
      req_bus.a_re <= data[0]; req_bus.a_im <= data[1];
      req_bus.b_re <= data[2]; req_bus.b_im <= data[3];
      req_bus.c_re <= data[4]; req_bus.c_im <= data[5];
      req_bus.d_re <= data[6]; req_bus.d_im <= data[7];
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(in_x, in_y, wre, wim, data);
   endtask

   task automatic idle_req();
      req_bus.valid <= 1'b0;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 3))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_random(int n, bit extreme);
      sample_type data [8];
      pos_type x;
      pos_type y;
      for (int i = 0; i < n; i++) begin
         foreach (data[e]) data[e] = extreme ? pick_sample() : sample_type'($urandom);
         x = $urandom_range(0, 1) ? pos_type'($urandom) : pos_type'($urandom_range(0, 1 << 20));
         y = $urandom_range(0, 1) ? pos_type'($urandom) : -pos_type'($urandom_range(0, 1 << 20));
         send_item(x, y, pick_sample(), pick_sample(), data, $urandom_range(0, 3) != 0);
      end
      idle_req();
   endtask

   // Receiver: random stalls, plus one long hold-off.
   initial begin
      acc_type got [8];
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      while (!rsp_done) begin
         stall = hold_off ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15));
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready) && !rsp_done);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[0] = rsp_bus.sum_a_re; got[1] = rsp_bus.sum_a_im;
            got[2] = rsp_bus.sum_b_re; got[3] = rsp_bus.sum_b_im;
            got[4] = rsp_bus.sum_c_re; got[5] = rsp_bus.sum_c_im;
            got[6] = rsp_bus.sum_d_re; got[7] = rsp_bus.sum_d_im;
            board.check_sums(got);
         end
      end
   end

   initial begin
      sample_type data [8];
      int limits [6] = '{1, 2, 5, 0, 4096, 8191};
      board = new();
      hold_off = 1'b0;
      rsp_done = 1'b0;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_WAVENUMBER;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.in_x = '0; req_bus.in_y = '0;
      req_bus.weight_re = '0; req_bus.weight_im = '0;
      req_bus.a_re = '0; req_bus.a_im = '0; req_bus.b_re = '0; req_bus.b_im = '0;
      req_bus.c_re = '0; req_bus.c_im = '0; req_bus.d_re = '0; req_bus.d_im = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, field extremes, saturation.
      foreach (data[e]) data[e] = 16'sh7FFF;
      send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, data, 0);
      foreach (data[e]) data[e] = 16'sh8000;
      send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh8000, data, 0);
      foreach (data[e]) data[e] = '0;
      send_item('0, '0, '0, '0, data, 0);
      idle_req();
      settle();
      write_csr(CSR_WAVENUMBER, 32'hFFFF_FFFF);
      write_csr(CSR_OUT_X, 32'h8000_0000);
      write_csr(CSR_OUT_Y, 32'h7FFF_FFFF);
      write_csr(CSR_INPUT_COUNT, 32'd0);
      send_random(6, 1);
      settle();
      // Full-scale items under the largest count.
      write_csr(CSR_WAVENUMBER, 32'd0);
      write_csr(CSR_INPUT_COUNT, 32'd4096);
      foreach (data[e]) data[e] = 16'sh8000;
      for (int i = 0; i < 100; i++)
         send_item(pos_type'($urandom), pos_type'($urandom), 16'sh8000, 16'sh8000, data, 0);
      idle_req();
      settle();
      // Lower the count mid-point: the result comes on the next item.
      write_csr(CSR_INPUT_COUNT, 32'd10);
      send_random(5, 1);
      settle();
      write_csr(CSR_INPUT_COUNT, 32'd3);
      send_random(1, 0);
      settle();

      // Random phases over several settings, one with a long receiver hold-off.
      for (int ph = 0; ph < 16; ph++) begin
         write_csr(CSR_WAVENUMBER, ph == 0 ? 32'd0 : $urandom);
         write_csr(CSR_OUT_X, $urandom);
         write_csr(CSR_OUT_Y, $urandom);
         write_csr(CSR_INPUT_COUNT, limits[ph % 6] == 4096 ? 32'd7 : limits[ph % 6]);
         if (ph % 5 == 4) write_csr(CSR_INPUT_COUNT, 32'd8191);
         if (ph == 3) hold_off = 1'b1;
         send_random(90, ph % 2);
         settle();
         // Finish a partial point at count one.
         write_csr(CSR_INPUT_COUNT, 32'd1);
         send_random(1, 0);
         settle();
      end

      rsp_done = 1'b1;
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: files.f
sv/wdmb_pkg.sv
sv/wdmb_req_if.sv
sv/wdmb_rsp_if.sv
sv/wdmb_ram.sv
sv/wdmb_phase.sv
sv/wdmb_lane.sv
sv/weighted_dft_matrix_beamformer.sv
test/wdmb_sums_board.sv
test/weighted_dft_matrix_beamformer_test.sv
